// ===== rtl/rvn_pkg.sv =====
package rvn_pkg;

    localparam int VALUE_W     = 24;
    localparam int WEIGHT_W    = 16;
    localparam int SCALE_W     = 32;
    localparam int EPS_W       = 32;
    localparam int SUM_W       = 64;
    localparam int CNT_MAX_W   = 17;
    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEFAULT_MAX_LEN = 4096;

    localparam logic [EPS_W-1:0]   EPS_RESET = 32'd4295;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0010_0000;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_NORM  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     sum;
        logic [CNT_MAX_W-1:0] count;
        logic [EPS_W-1:0]     eps;
    } scale_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] scale;
    } scale_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SCALE,
        ST_MUL2,
        ST_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MEAN,
        SC_EPS,
        SC_RECIP,
        SC_ROOT,
        SC_DONE
    } scale_state_t;

endpackage

// ===== rtl/rvn_front.sv =====
module rvn_front
    import rvn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  q_valid,
    input  logic                  q_ready,
    output item_t                 q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            items_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    item_t            in_item;

    // classify the incoming word
    always_comb begin
        in_item.op     = s_tuser ? OP_NORM : OP_ACCUM;
        in_item.value  = s_tdata[VALUE_W-1:0];
        in_item.weight = s_tdata[VALUE_W+WEIGHT_W-1:VALUE_W];
        in_item.last   = s_tlast;
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = items_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            items_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/rvn_scale_unit.sv =====
module rvn_scale_unit
    import rvn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  scale_req_t req,
    output scale_rsp_t rsp
);

    localparam int DVD_W     = 73;
    localparam int STEP_W    = 7;
    localparam int DIV_LAST  = 72;
    localparam int ROOT_LAST = 31;
    localparam int SREM_W    = 36;

    scale_state_t        state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [SUM_W-1:0]    dvs_reg;
    logic [EPS_W-1:0]    eps_reg;
    logic [SCALE_W-1:0]  root_reg;
    logic [SREM_W-1:0]   srem_reg;

    logic [SUM_W:0]      rem_shift, rem_step;
    logic                div_ge;
    logic [SUM_W:0]      m_add;
    logic [SUM_W-1:0]    m_val;
    logic                m_small;
    logic [SREM_W-1:0]   srem_shift, trial, srem_step;
    logic                root_ge;
    logic                step_zero;

    // restoring divide step: one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        div_ge    = (rem_shift >= {1'b0, dvs_reg});
        rem_step  = div_ge ? rem_shift - {1'b0, dvs_reg} : rem_shift;
    end

    // mean plus epsilon, saturating
    always_comb begin
        m_add   = {1'b0, dvd_reg[SUM_W-1:0]} + {{(SUM_W-EPS_W+1){1'b0}}, eps_reg};
        m_val   = m_add[SUM_W] ? '1 : m_add[SUM_W-1:0];
        m_small = (m_val <= SUM_W'(256));
    end

    // square root step: one root bit per cycle
    always_comb begin
        srem_shift = {srem_reg[SREM_W-3:0], dvd_reg[SUM_W-1:SUM_W-2]};
        trial      = {2'b00, root_reg, 2'b01};
        root_ge    = (srem_shift >= trial);
        srem_step  = root_ge ? srem_shift - trial : srem_shift;
    end

    assign step_zero = (step_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE:  if (req.start) state_next = SC_MEAN;
            SC_MEAN:  if (step_zero) state_next = SC_EPS;
            SC_EPS:   state_next = m_small ? SC_DONE : SC_RECIP;
            SC_RECIP: if (step_zero) state_next = SC_ROOT;
            SC_ROOT:  if (step_zero) state_next = SC_DONE;
            SC_DONE:  state_next = SC_IDLE;
            default:  state_next = SC_IDLE;
        endcase
    end

    always_comb begin
        rsp.done  = (state_reg == SC_DONE);
        rsp.scale = root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    dvd_reg  <= {{(DVD_W-SUM_W){1'b0}}, req.sum};
                    // an empty count divides by one
                    dvs_reg  <= (req.count == '0) ? SUM_W'(1)
                                                  : {{(SUM_W-CNT_MAX_W){1'b0}}, req.count};
                    rem_reg  <= '0;
                    eps_reg  <= req.eps;
                    step_reg <= STEP_W'(DIV_LAST);
                end
            end
            SC_MEAN, SC_RECIP: begin
                rem_reg  <= rem_step[SUM_W-1:0];
                dvd_reg  <= {dvd_reg[DVD_W-2:0], div_ge};
                if (step_zero) begin
                    srem_reg <= '0;
                    root_reg <= '0;
                    step_reg <= STEP_W'(ROOT_LAST);
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            SC_EPS: begin
                if (m_small) begin
                    root_reg <= '1;
                end else begin
                    dvs_reg  <= m_val;
                    dvd_reg  <= {1'b1, {(DVD_W-1){1'b0}}};
                    rem_reg  <= '0;
                    step_reg <= STEP_W'(DIV_LAST);
                end
            end
            SC_ROOT: begin
                srem_reg <= srem_step;
                root_reg <= {root_reg[SCALE_W-2:0], root_ge};
                dvd_reg  <= {dvd_reg[DVD_W-3:0], 2'b00};
                step_reg <= step_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/rvn_back.sv =====
module rvn_back
    import rvn_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [EPS_W-1:0]       cfg_data,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  item_t                  q_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SQ_W  = 2 * VALUE_W - 1;
    localparam int P1_W  = VALUE_W + SCALE_W + 1;
    localparam int PM_W  = P1_W - 20;
    localparam int P_W   = PM_W + 1;
    localparam int P2_W  = P_W + WEIGHT_W;
    localparam int YM_W  = P2_W - 12;

    back_state_t              state_reg, state_next;
    item_t                    cur_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [P1_W-1:0]   prod1_reg;
    logic signed [P2_W-1:0]   prod2_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic [EPS_W-1:0]         eps_reg;
    logic                     out_valid_reg;
    logic [VALUE_W-1:0]       out_data_reg;
    logic                     out_last_reg;

    logic                     pop;
    logic                     out_load;
    logic [2*VALUE_W-1:0]     sq_full;
    logic signed [P1_W-1:0]   prod1_full;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_sat, sum_acc;
    logic [CNT_W-1:0]         count_acc;
    logic                     room;
    logic [P1_W-1:0]          mag1, rnd1;
    logic [PM_W-1:0]          p_mag;
    logic signed [P_W-1:0]    p_val;
    logic signed [P2_W-1:0]   prod2_full;
    logic [P2_W-1:0]          mag2, rnd2;
    logic [YM_W-1:0]          y_mag;
    logic [VALUE_W-1:0]       y_sat;
    scale_req_t               scale_req;
    scale_rsp_t               scale_rsp;

    rvn_scale_unit u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scale_req),
        .rsp     (scale_rsp)
    );

    assign sq_full    = $signed(q_item.value) * $signed(q_item.value);
    assign prod1_full = $signed(q_item.value) * $signed({1'b0, scale_reg});

    // saturating accumulate, elements past the length limit are dropped
    always_comb begin
        sum_add   = {1'b0, sum_reg} + {{(SUM_W-SQ_W+1){1'b0}}, sq_reg};
        sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        room      = (count_reg < CNT_W'(MAX_LEN));
        sum_acc   = room ? sum_sat : sum_reg;
        count_acc = room ? count_reg + 1'b1 : count_reg;
    end

    // value * scale rounded half away from zero to q.16
    always_comb begin
        mag1       = prod1_reg[P1_W-1] ? P1_W'(-prod1_reg) : P1_W'(prod1_reg);
        rnd1       = mag1 + P1_W'(1 << 19);
        p_mag      = rnd1[P1_W-1:20];
        p_val      = prod1_reg[P1_W-1] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
        prod2_full = p_val * $signed(cur_reg.weight);
    end

    // times weight, rounded and saturated to 24 bits
    always_comb begin
        mag2 = prod2_reg[P2_W-1] ? P2_W'(-prod2_reg) : P2_W'(prod2_reg);
        rnd2 = mag2 + P2_W'(1 << 11);
        y_mag = rnd2[P2_W-1:12];
        if (prod2_reg[P2_W-1]) begin
            if (y_mag > YM_W'(8388608)) begin
                y_sat = 24'h800000;
            end else begin
                y_sat = -y_mag[VALUE_W-1:0];
            end
        end else begin
            if (y_mag > YM_W'(8388607)) begin
                y_sat = 24'h7FFFFF;
            end else begin
                y_sat = y_mag[VALUE_W-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.op == OP_ACCUM) ? ST_ACC : ST_MUL2;
                end
            end
            ST_ACC:   state_next = cur_reg.last ? ST_SCALE : ST_IDLE;
            ST_SCALE: if (scale_rsp.done) state_next = ST_IDLE;
            ST_MUL2:  state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready         = (state_reg == ST_IDLE);
        out_load        = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
        scale_req.start = (state_reg == ST_ACC) && cur_reg.last;
        scale_req.sum   = sum_acc;
        scale_req.count = CNT_MAX_W'(count_acc);
        scale_req.eps   = eps_reg;
    end

    assign pop      = q_valid && q_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            scale_reg     <= SCALE_ONE;
            eps_reg       <= EPS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                eps_reg <= cfg_data;
            end
            if (state_reg == ST_ACC) begin
                if (cur_reg.last) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= sum_acc;
                    count_reg <= count_acc;
                end
            end
            if (state_reg == ST_SCALE && scale_rsp.done) begin
                scale_reg <= scale_rsp.scale;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg   <= q_item;
            sq_reg    <= sq_full[SQ_W-1:0];
            prod1_reg <= prod1_full;
        end
        if (state_reg == ST_MUL2) begin
            prod2_reg <= prod2_full;
        end
        if (out_load) begin
            out_data_reg <= y_sat;
            out_last_reg <= cur_reg.last;
        end
    end

`ifndef SYNTH
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count beyond length limit");

    a_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        scale_rsp.done |-> (state_reg == ST_SCALE))
        else $error("scale finished while back end not waiting");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        scale_req.start |=> (sum_reg == '0 && count_reg == '0))
        else $error("sum or count not cleared after last");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_valid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result dropped while output stalled");
`endif

endmodule

// ===== rtl/rms_vector_normalizer.sv =====
// rms normalizer over a stream of vector elements, two passes per vector
// input words: tuser selects accumulate (0) or normalize (1), tdata holds
// the q8.16 element and the q4.12 weight, tlast closes the vector
// accumulate words add the element square into a saturating sum and give no
// result; the last one starts the 1/sqrt(mean + epsilon) computation
// normalize words give one output word each: element * scale * weight in
// q8.16, saturated, tlast copied through
// epsilon is written on the cfg channel only while the block is idle: a user
// rule the block does not enforce; an accumulate word is squared as it
// leaves the queue and is added in ST_ACC; a normalize word is multiplied
// by the scale as it leaves the queue, by the weight in ST_MUL2 and goes to
// the output register in ST_OUT; a last accumulate word starts two 73-step
// restoring divides, an epsilon step, a 32-step square root and a done
// state on one unit (no second divide or root when mean plus epsilon is at
// most 256), during which no further word is processed; a 4-word queue in
// front keeps s_tready up until it is full; a stalled m_tready holds the
// output register and then the back end; reset empties the queue, clears
// sum and count, sets scale to 1.0 and epsilon to its default
module rms_vector_normalizer
    import rvn_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // element_value, gain_weight
    input  logic                   s_tuser,   // command
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // normalized_value
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [EPS_W-1:0]       cfg_data
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    assign cfg_ready = 1'b1;

    rvn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    rvn_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
